// ----- rtl/crr_pkg.sv -----
// Shared types and constants of the chunked request reassembler.
package crr_pkg;

  localparam int unsigned HDR_LEN     = 12;
  localparam int unsigned STORE_DEPTH = 16384;
  localparam int unsigned STORE_AW    = 14;

  localparam logic [7:0] MAGIC_L     = 8'h4C;
  localparam logic [7:0] MAGIC_R     = 8'h52;
  localparam logic [7:0] HDR_VERSION = 8'd1;
  localparam logic [7:0] HDR_KIND    = 8'd1;

  localparam logic [11:0] IDLE_LIMIT_RST = 12'd3000;
  localparam logic [11:0] IDLE_SAT       = 12'hFFF;

  localparam logic [1:0] CMD_REPORT  = 2'd0;
  localparam logic [1:0] CMD_POLL    = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;
  localparam logic [1:0] CMD_READ    = 2'd3;

  localparam logic [2:0] VERDICT_NONE      = 3'd0;
  localparam logic [2:0] VERDICT_ACCEPT    = 3'd1;
  localparam logic [2:0] VERDICT_BAD       = 3'd2;
  localparam logic [2:0] VERDICT_RANGE     = 3'd3;
  localparam logic [2:0] VERDICT_FOREIGN   = 3'd4;
  localparam logic [2:0] VERDICT_DUPLICATE = 3'd5;
  localparam logic [2:0] VERDICT_SHORT     = 3'd6;

  typedef struct packed {
    logic [1:0]          command;
    logic [7:0]          report_byte;
    logic [STORE_AW-1:0] read_address;
  } crr_in_t;

  typedef struct packed {
    logic [2:0]          verdict;
    logic                ready_flag;
    logic                active_flag;
    logic                timed_out;
    logic [7:0]          held_command;
    logic [15:0]         held_id;
    logic [STORE_AW-1:0] payload_size;
    logic [7:0]          read_data;
  } crr_out_t;

  // Result fields produced by the engine; read data comes from the RAM.
  typedef struct packed {
    logic [2:0]          verdict;
    logic                ready_flag;
    logic                active_flag;
    logic                timed_out;
    logic [7:0]          held_command;
    logic [15:0]         held_id;
    logic [STORE_AW-1:0] payload_size;
  } crr_eng_res_t;

  typedef struct packed {
    logic                wr_en;
    logic [STORE_AW-1:0] wr_addr;
    logic [7:0]          wr_data;
    logic                rd_en;
    logic [STORE_AW-1:0] rd_addr;
  } crr_ram_ctl_t;

endpackage

// ----- rtl/crr_payload_ram.sv -----
// Payload store: single write port, one registered read port.
module crr_payload_ram import crr_pkg::*; (
  input  logic         clk,
  input  crr_ram_ctl_t ctl,
  output logic [7:0]   rd_data
);

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[ctl.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/crr_engine.sv -----
// Assembly state, header checks and store addressing; one item per cycle when stepped.
module crr_engine import crr_pkg::*; #(
  parameter int unsigned CHUNK_BYTES  = 52,
  parameter int unsigned MAX_CHUNKS   = 255,
  parameter int unsigned REPORT_BYTES = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [11:0]  cfg_wdata,
  input  logic         step,
  input  crr_in_t      item,
  output crr_eng_res_t res,
  output crr_ram_ctl_t ram_ctl
);

  logic         assembling_r, assembling_nxt;
  logic         complete_r, complete_nxt;
  logic [7:0]   cur_cmd_r, cur_cmd_nxt;
  logic [15:0]  cur_id_r, cur_id_nxt;
  logic [7:0]   total_r, total_nxt;
  logic [7:0]   chunks_in_r, chunks_in_nxt;
  logic [5:0]   last_len_r, last_len_nxt;
  logic [11:0]  idle_r, idle_nxt;
  logic [5:0]   pos_r, pos_nxt;
  logic [7:0]   hdr_r [HDR_LEN];
  logic [7:0]   hdr_nxt [HDR_LEN];
  logic         wr_en_r, wr_en_nxt;
  logic [255:0] map_r, map_nxt;
  logic [11:0]  limit_r;

  logic [7:0]   hcmd;
  logic [15:0]  hid;
  logic [15:0]  hidx;
  logic [7:0]   htot;
  logic [7:0]   hlen;
  logic         other;
  logic         bad;
  logic         restart;
  logic [11:0]  idle_inc;
  logic [5:0]   pay_off;

  assign hcmd    = hdr_r[4];
  assign hid     = {hdr_r[7], hdr_r[6]};
  assign hidx    = {hdr_r[9], hdr_r[8]};
  assign htot    = hdr_r[10];
  assign hlen    = item.report_byte;
  assign other   = assembling_r &&
                   (hcmd != cur_cmd_r || hid != cur_id_r || htot != total_r);
  assign bad     = complete_r || hdr_r[0] != MAGIC_L || hdr_r[1] != MAGIC_R ||
                   hdr_r[2] != HDR_VERSION || hdr_r[3] != HDR_KIND ||
                   htot == 8'd0 || {1'b0, htot} > 9'(MAX_CHUNKS) ||
                   hlen > 8'(CHUNK_BYTES);
  assign restart = !assembling_r || (other && hidx == 16'd0);
  assign idle_inc = (idle_r != IDLE_SAT) ? idle_r + 12'd1 : idle_r;
  assign pay_off  = pos_r - 6'(HDR_LEN);

  always_comb begin
    assembling_nxt = assembling_r;
    complete_nxt   = complete_r;
    cur_cmd_nxt    = cur_cmd_r;
    cur_id_nxt     = cur_id_r;
    total_nxt      = total_r;
    chunks_in_nxt  = chunks_in_r;
    last_len_nxt   = last_len_r;
    idle_nxt       = idle_r;
    pos_nxt        = pos_r;
    hdr_nxt        = hdr_r;
    wr_en_nxt      = wr_en_r;
    map_nxt        = map_r;
    res            = '0;
    res.verdict    = VERDICT_NONE;
    ram_ctl        = '0;

    if (step) begin
      case (item.command)
        CMD_REPORT: begin
          if (pos_r < 6'(HDR_LEN)) begin
            hdr_nxt[pos_r[3:0]] = item.report_byte;
            if (pos_r == 6'(HDR_LEN - 1)) begin
              wr_en_nxt = 1'b0;
              if (bad) begin
                res.verdict = VERDICT_BAD;
              end else if (hidx >= {8'd0, htot}) begin
                res.verdict = VERDICT_RANGE;
              end else begin
                // A new assembly is opened before the duplicate and short checks.
                if (restart) begin
                  assembling_nxt = 1'b1;
                  cur_cmd_nxt    = hcmd;
                  cur_id_nxt     = hid;
                  total_nxt      = htot;
                  chunks_in_nxt  = 8'd0;
                  last_len_nxt   = 6'd0;
                  idle_nxt       = 12'd0;
                  map_nxt        = '0;
                end
                if (!restart && other) begin
                  res.verdict = VERDICT_FOREIGN;
                end else if (map_nxt[hidx[7:0]]) begin
                  res.verdict = VERDICT_DUPLICATE;
                end else if (({1'b0, hidx} + 17'd1) < {9'd0, htot} &&
                             hlen != 8'(CHUNK_BYTES)) begin
                  res.verdict = VERDICT_SHORT;
                end else begin
                  res.verdict           = VERDICT_ACCEPT;
                  idle_nxt              = 12'd0;
                  map_nxt[hidx[7:0]]    = 1'b1;
                  chunks_in_nxt         = chunks_in_nxt + 8'd1;
                  if (({1'b0, hidx} + 17'd1) == {9'd0, htot}) begin
                    last_len_nxt = hlen[5:0];
                  end
                  if (chunks_in_nxt == total_nxt && last_len_nxt != 6'd0) begin
                    complete_nxt = 1'b1;
                  end
                  wr_en_nxt = 1'b1;
                end
              end
            end
          end else if (wr_en_r && {2'b00, pay_off} < hdr_r[11]) begin
            ram_ctl.wr_en   = 1'b1;
            ram_ctl.wr_addr = STORE_AW'(hdr_r[8]) * STORE_AW'(CHUNK_BYTES) +
                              STORE_AW'(pay_off);
            ram_ctl.wr_data = item.report_byte;
          end
          if (({1'b0, pos_r} + 7'd1) >= 7'(REPORT_BYTES)) begin
            pos_nxt   = 6'd0;
            wr_en_nxt = 1'b0;
          end else begin
            pos_nxt = pos_r + 6'd1;
          end
        end
        CMD_POLL: begin
          if (!complete_r && assembling_r) begin
            idle_nxt = idle_inc;
            if (idle_inc >= limit_r) begin
              assembling_nxt = 1'b0;
              complete_nxt   = 1'b0;
              chunks_in_nxt  = 8'd0;
              last_len_nxt   = 6'd0;
              idle_nxt       = 12'd0;
              map_nxt        = '0;
              res.timed_out  = 1'b1;
            end
          end
        end
        CMD_RELEASE: begin
          assembling_nxt = 1'b0;
          complete_nxt   = 1'b0;
          chunks_in_nxt  = 8'd0;
          last_len_nxt   = 6'd0;
          idle_nxt       = 12'd0;
          map_nxt        = '0;
        end
        CMD_READ: begin
          ram_ctl.rd_en   = 1'b1;
          ram_ctl.rd_addr = item.read_address;
        end
        default: begin
        end
      endcase
    end

    res.ready_flag   = complete_nxt;
    res.active_flag  = assembling_nxt;
    res.held_command = cur_cmd_nxt;
    res.held_id      = cur_id_nxt;
    if (complete_nxt && total_nxt != 8'd0) begin
      res.payload_size = STORE_AW'(total_nxt - 8'd1) * STORE_AW'(CHUNK_BYTES) +
                         STORE_AW'(last_len_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      assembling_r <= 1'b0;
      complete_r   <= 1'b0;
      cur_cmd_r    <= 8'd0;
      cur_id_r     <= 16'd0;
      total_r      <= 8'd0;
      chunks_in_r  <= 8'd0;
      last_len_r   <= 6'd0;
      idle_r       <= 12'd0;
      pos_r        <= 6'd0;
      for (int i = 0; i < HDR_LEN; i++) begin
        hdr_r[i] <= 8'd0;
      end
      wr_en_r      <= 1'b0;
      map_r        <= '0;
      limit_r      <= IDLE_LIMIT_RST;
    end else begin
      assembling_r <= assembling_nxt;
      complete_r   <= complete_nxt;
      cur_cmd_r    <= cur_cmd_nxt;
      cur_id_r     <= cur_id_nxt;
      total_r      <= total_nxt;
      chunks_in_r  <= chunks_in_nxt;
      last_len_r   <= last_len_nxt;
      idle_r       <= idle_nxt;
      pos_r        <= pos_nxt;
      hdr_r        <= hdr_nxt;
      wr_en_r      <= wr_en_nxt;
      map_r        <= map_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

endmodule

// ----- rtl/chunked_request_reassembler.sv -----
// Top level of the chunked request reassembler.
// Each item is captured in an input register, handled by the engine logic, and
// placed in an output register, so one item is taken every clock unless out_stall
// holds a waiting result. A finished result may wait on out_stall while the next item
// is already taken in. Payload read data comes from the registered read port of the
// 16K-byte payload RAM, which is loaded at the same step; the RAM needs no clearing
// after reset. Header checks, the chunk bitmap and the idle timer all update in that
// step. The idle limit is set through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce.
module chunked_request_reassembler import crr_pkg::*; #(
  parameter int unsigned CHUNK_BYTES  = 52,
  parameter int unsigned MAX_CHUNKS   = 255,
  parameter int unsigned REPORT_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  crr_in_t     in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output crr_out_t    out_item
);

  logic         in_vld_r;
  crr_in_t      in_item_r;
  logic         out_vld_r;
  crr_eng_res_t out_res_r;
  logic         rd_sel_r;
  logic         adv;
  crr_eng_res_t eng_res;
  crr_ram_ctl_t ram_ctl;
  logic [7:0]   ram_q;

  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;

  crr_engine #(
    .CHUNK_BYTES  (CHUNK_BYTES),
    .MAX_CHUNKS   (MAX_CHUNKS),
    .REPORT_BYTES (REPORT_BYTES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (adv),
    .item      (in_item_r),
    .res       (eng_res),
    .ram_ctl   (ram_ctl)
  );

  crr_payload_ram u_ram (
    .clk     (clk),
    .ctl     (ram_ctl),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
    if (adv) begin
      out_res_r <= eng_res;
      rd_sel_r  <= (in_item_r.command == CMD_READ);
    end
  end

  // The RAM read register only moves on a read step, so it holds under stall.
  always_comb begin
    out_item.verdict      = out_res_r.verdict;
    out_item.ready_flag   = out_res_r.ready_flag;
    out_item.active_flag  = out_res_r.active_flag;
    out_item.timed_out    = out_res_r.timed_out;
    out_item.held_command = out_res_r.held_command;
    out_item.held_id      = out_res_r.held_id;
    out_item.payload_size = out_res_r.payload_size;
    out_item.read_data    = rd_sel_r ? ram_q : 8'd0;
  end

  assign out_valid = out_vld_r;

endmodule

// ----- rtl/crr_checker.sv -----
// Port-level assertions for the chunked request reassembler, bound to the top level.
module crr_checker import crr_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_stall,
  input crr_out_t out_item
);

  // A stalled result must stay put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // A waiting complete request is always an active assembly.
  a_ready_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.ready_flag |-> out_item.active_flag)
    else $error("ready without active assembly");

  // A timeout drops the assembly and carries no verdict.
  a_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.timed_out |->
      !out_item.active_flag && out_item.verdict == VERDICT_NONE)
    else $error("timeout left assembly active or gave a verdict");

  // A payload size is only reported for a complete request.
  a_size_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.payload_size != '0 |-> out_item.ready_flag)
    else $error("payload size without complete request");

endmodule

bind chunked_request_reassembler crr_checker u_crr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
